@@ rtl/fstu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fstu_pkg
// Shared types, widths and register codes of the flame source term unit.
// ----------------------------------------------------------------------------
package fstu_pkg;

  // default build parameters
  localparam int WINDOW_TABLE_DEPTH_DEF = 256;
  localparam int FRACTION_BITS_DEF      = 16;

  // port widths
  localparam int FRAC_IN_W  = 17;
  localparam int TEMP_W     = 20;
  localparam int RATE_W     = 32;
  localparam int ZST_W      = 16;
  localparam int MSRC_W     = 33;
  localparam int HEAT_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [ZST_W-1:0]  STOICH_RST  = 16'd32768;
  localparam logic [RATE_W-1:0] INV_WID_RST = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODEL_MODE      = 3'd0,
    REG_RXN_RATE        = 3'd1,
    REG_HEAT_GAIN       = 3'd2,
    REG_IGNITION_TEMP   = 3'd3,
    REG_STOICH_FRACTION = 3'd4,
    REG_INV_MIX_WIDTH   = 3'd5,
    REG_MIX_RATE        = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    MODE_PREMIXED     = 1'b0,
    MODE_NON_PREMIXED = 1'b1
  } model_mode_e;

  typedef struct packed {
    model_mode_e        model_mode;
    logic [RATE_W-1:0]  rxn_rate;
    logic [RATE_W-1:0]  heat_gain;
    logic [TEMP_W-1:0]  ign_temp;
    logic [ZST_W-1:0]   stoich_fraction;
    logic [RATE_W-1:0]  inverse_mixing_width;
    logic [RATE_W-1:0]  mix_rate;
  } cfg_t;

endpackage

@@ rtl/fstu_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fstu_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module fstu_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fstu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fstu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output fstu_pkg::cfg_t                 cfg_o
);
  import fstu_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODEL_MODE:      cfg_d.model_mode           = model_mode_e'(cfg_wdata_i[0]);
        REG_RXN_RATE:        cfg_d.rxn_rate             = cfg_wdata_i;
        REG_HEAT_GAIN:       cfg_d.heat_gain            = cfg_wdata_i;
        REG_IGNITION_TEMP:   cfg_d.ign_temp             = cfg_wdata_i[TEMP_W-1:0];
        REG_STOICH_FRACTION: cfg_d.stoich_fraction      = cfg_wdata_i[ZST_W-1:0];
        REG_INV_MIX_WIDTH:   cfg_d.inverse_mixing_width = cfg_wdata_i;
        REG_MIX_RATE:        cfg_d.mix_rate             = cfg_wdata_i;
        default: ; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.model_mode           <= MODE_PREMIXED;
      cfg_q.rxn_rate             <= '0;
      cfg_q.heat_gain            <= '0;
      cfg_q.ign_temp             <= '0;
      cfg_q.stoich_fraction      <= STOICH_RST;
      cfg_q.inverse_mixing_width <= INV_WID_RST;
      cfg_q.mix_rate             <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/fstu_window_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fstu_window_rom
// Gaussian window table exp(-x^2) over x in [0,4), registered lookup.
// ----------------------------------------------------------------------------
module fstu_window_rom #(
  parameter int WINDOW_TABLE_DEPTH = fstu_pkg::WINDOW_TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS      = fstu_pkg::FRACTION_BITS_DEF,
  localparam int IDX_W             = $clog2(WINDOW_TABLE_DEPTH)
) (
  input  logic                     clk_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic                     zero_i,
  output logic [FRACTION_BITS:0]   word_o
);

  typedef logic [FRACTION_BITS:0] rom_word_t;
  typedef rom_word_t rom_array_t [WINDOW_TABLE_DEPTH];

  localparam logic [63:0] ONE_64  = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] DEPTH_SQ =
    64'(WINDOW_TABLE_DEPTH) * 64'(WINDOW_TABLE_DEPTH);

  // restoring long division, only run while the table is built
  function automatic logic [63:0] div_u64(input logic [63:0] num,
                                          input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-u by series and reciprocal, then raised to the 16th power by squaring
  function automatic rom_array_t build_rom();
    rom_array_t  tbl;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    int          i;
    int          k;
    int          s;
    for (i = 0; i < WINDOW_TABLE_DEPTH; i++) begin
      u    = div_u64((64'(i) * 64'(i)) << 32, DEPTH_SQ);
      term = 64'd1 << 32;
      sum  = term;
      for (k = 1; k <= 24; k++) begin
        term = div_u64((term * u) >> 32, 64'(k));
        sum  = sum + term;
      end
      r = div_u64(64'hFFFF_FFFF_FFFF_FFFF, sum);
      for (s = 0; s < 4; s++) begin
        r = (r * r) >> 32;
      end
      r = (r + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
      if (r > ONE_64) begin
        r = ONE_64;
      end
      tbl[i] = r[FRACTION_BITS:0];
    end
    return tbl;
  endfunction

  localparam rom_array_t WINDOW_ROM = build_rom();

  rom_word_t word_q;

  always_ff @(posedge clk_i) begin
    word_q <= zero_i ? '0 : WINDOW_ROM[idx_i];
  end

  assign word_o = word_q;

endmodule

@@ rtl/flame_source_term_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flame_source_term_unit
// Per-cell combustion source terms (premixed or non-premixed model) in fixed
// point, one cell per clock through a seven stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+----------------
//  command  | start, busy, progress_i, mixture_fraction_i,    | start && !busy
//           | temperature_i                                    |
//  result   | result_valid_o, prog_src_o,                      | strobe, 1 cycle
//           | mix_src_o, heat_rate_o,                          |
//           | invalid_state_o                                  |
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i,           | valid && ready
//           | cfg_wdata_i                                      |
//
//  - a new cell is taken every cycle; its result strobe comes out of the
//    seven register stages (input checks, four multiplier levels, the
//    window lookup and the heat multiply each own a stage)
//  - busy stays low: nothing in the pipeline ever waits, and the receiver
//    takes each result in its strobe cycle
//  - reset clears the valid bits and loads the register defaults; the window
//    table is constant, so no clearing pass is needed
//  - config transactions are taken at any time, ready is always high
// ----------------------------------------------------------------------------
module flame_source_term_unit #(
  parameter int WINDOW_TABLE_DEPTH = fstu_pkg::WINDOW_TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS      = fstu_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic [fstu_pkg::FRAC_IN_W-1:0]      progress_i,
  input  logic [fstu_pkg::FRAC_IN_W-1:0]      mixture_fraction_i,
  input  logic [fstu_pkg::TEMP_W-1:0]         temperature_i,
  // result
  output logic                                result_valid_o,
  output logic [fstu_pkg::RATE_W-1:0]         prog_src_o,
  output logic signed [fstu_pkg::MSRC_W-1:0]  mix_src_o,
  output logic [fstu_pkg::HEAT_W-1:0]         heat_rate_o,
  output logic                                invalid_state_o,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fstu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fstu_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import fstu_pkg::*;

  localparam int FB      = FRACTION_BITS;
  localparam int FRAC_W  = FB + 1;              // fraction 0..1.0 inclusive
  localparam int IDX_W   = $clog2(WINDOW_TABLE_DEPTH);
  localparam int CMP_W   = (FRAC_W > FRAC_IN_W) ? FRAC_W : FRAC_IN_W;
  localparam int MAG_W   = FRAC_IN_W;
  localparam int IDXP_W  = FB + 2 + IDX_W;
  localparam int STAGES  = 7;
  localparam logic [FRAC_W-1:0] ONE_FX = {1'b1, {FB{1'b0}}};

  cfg_t cfg;

  fstu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // pipeline never stalls
  assign busy = 1'b0;

  logic               accept;
  logic [STAGES:1]    vld_q, vld_d;

  assign accept = start && !busy;
  assign vld_d  = {vld_q[STAGES-1:1], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: range checks, ignition test, |z - zst| and 1 - c
  // --------------------------------------------------------------------------
  logic               inv1_d, kill1_d, pos1_d;
  logic [MAG_W-1:0]   mag1_d;
  logic [FRAC_W-1:0]  om1_d, c1_d;
  logic               inv1_q, kill1_q, pos1_q;
  logic [MAG_W-1:0]   mag1_q;
  logic [FRAC_W-1:0]  om1_q, c1_q;

  always_comb begin
    inv1_d  = (CMP_W'(progress_i) > CMP_W'(ONE_FX)) ||
              (CMP_W'(mixture_fraction_i) > CMP_W'(ONE_FX));
    kill1_d = inv1_d || (temperature_i < cfg.ign_temp);
    pos1_d  = mixture_fraction_i > MAG_W'(cfg.stoich_fraction);
    mag1_d  = pos1_d ? (mixture_fraction_i - MAG_W'(cfg.stoich_fraction))
                     : (MAG_W'(cfg.stoich_fraction) - mixture_fraction_i);
    // c is at most 1.0 whenever the result is used
    c1_d    = FRAC_W'(progress_i);
    om1_d   = ONE_FX - c1_d;
  end

  always_ff @(posedge clk_i) begin
    inv1_q  <= inv1_d;
    kill1_q <= kill1_d;
    pos1_q  <= pos1_d;
    mag1_q  <= mag1_d;
    om1_q   <= om1_d;
    c1_q    <= c1_d;
  end

  // --------------------------------------------------------------------------
  // stage 2: c*(1-c), scaled deviation n and relaxation magnitude
  // --------------------------------------------------------------------------
  logic [2*FRAC_W-1:0]  cq_prod;
  logic [MAG_W+31:0]    a_prod, rel_prod;
  logic [63:0]          a_full, rel_full;
  logic [FB-1:0]        q2_d, q2_q;
  logic [FB+1:0]        a2_d, a2_q;
  logic                 abig2_d, abig2_q;
  logic [RATE_W-1:0]    rel2_d, rel2_q;
  logic                 inv2_q, kill2_q, pos2_q;
  logic [FRAC_W-1:0]    om2_q;

  always_comb begin
    cq_prod  = (2*FRAC_W)'(c1_q) * (2*FRAC_W)'(om1_q);
    q2_d     = cq_prod[2*FB-1:FB];
    a_prod   = (MAG_W+32)'(mag1_q) * (MAG_W+32)'(cfg.inverse_mixing_width);
    a_full   = 64'(a_prod) >> FB;
    a2_d     = a_full[FB+1:0];
    abig2_d  = |a_full[63:FB+2];            // |n| at or above 4.0
    rel_prod = (MAG_W+32)'(mag1_q) * (MAG_W+32)'(cfg.mix_rate);
    rel_full = 64'(rel_prod) >> FB;
    rel2_d   = (|rel_full[63:32]) ? '1 : rel_full[31:0];
  end

  always_ff @(posedge clk_i) begin
    q2_q    <= q2_d;
    a2_q    <= a2_d;
    abig2_q <= abig2_d;
    rel2_q  <= rel2_d;
    inv2_q  <= inv1_q;
    kill2_q <= kill1_q;
    pos2_q  <= pos1_q;
    om2_q   <= om1_q;
  end

  // --------------------------------------------------------------------------
  // stage 3: premixed source and window table index
  // --------------------------------------------------------------------------
  logic [RATE_W+FB-1:0] pm_prod;
  logic [IDXP_W-1:0]    idx_prod;
  logic [RATE_W-1:0]    pm3_d, pm3_q;
  logic [IDX_W-1:0]     idx3_d, idx3_q;
  logic                 abig3_q, inv3_q, kill3_q, pos3_q;
  logic [RATE_W-1:0]    rel3_q;
  logic [FRAC_W-1:0]    om3_q;

  always_comb begin
    pm_prod  = (RATE_W+FB)'(cfg.rxn_rate) * (RATE_W+FB)'(q2_q);
    pm3_d    = pm_prod[FB+RATE_W-1:FB];
    idx_prod = IDXP_W'(a2_q) * IDXP_W'(WINDOW_TABLE_DEPTH);
    idx3_d   = idx_prod[IDXP_W-1:FB+2];
  end

  always_ff @(posedge clk_i) begin
    pm3_q   <= pm3_d;
    idx3_q  <= idx3_d;
    abig3_q <= abig2_q;
    inv3_q  <= inv2_q;
    kill3_q <= kill2_q;
    pos3_q  <= pos2_q;
    rel3_q  <= rel2_q;
    om3_q   <= om2_q;
  end

  // --------------------------------------------------------------------------
  // stage 4: window lookup, out-of-range deviation reads zero
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0]  w4;
  logic [RATE_W-1:0]  pm4_q, rel4_q;
  logic               inv4_q, kill4_q, pos4_q;
  logic [FRAC_W-1:0]  om4_q;

  fstu_window_rom #(
    .WINDOW_TABLE_DEPTH (WINDOW_TABLE_DEPTH),
    .FRACTION_BITS      (FRACTION_BITS)
  ) u_window_rom (
    .clk_i  (clk_i),
    .idx_i  (idx3_q),
    .zero_i (abig3_q),
    .word_o (w4)
  );

  always_ff @(posedge clk_i) begin
    pm4_q   <= pm3_q;
    rel4_q  <= rel3_q;
    inv4_q  <= inv3_q;
    kill4_q <= kill3_q;
    pos4_q  <= pos3_q;
    om4_q   <= om3_q;
  end

  // --------------------------------------------------------------------------
  // stage 5: mix rate times window
  // --------------------------------------------------------------------------
  logic [RATE_W+FRAC_W-1:0] m_prod;
  logic [RATE_W-1:0]        m5_d, m5_q;
  logic [RATE_W-1:0]        pm5_q, rel5_q;
  logic                     inv5_q, kill5_q, pos5_q;
  logic [FRAC_W-1:0]        om5_q;

  always_comb begin
    m_prod = (RATE_W+FRAC_W)'(cfg.mix_rate) * (RATE_W+FRAC_W)'(w4);
    m5_d   = m_prod[FB+RATE_W-1:FB];
  end

  always_ff @(posedge clk_i) begin
    m5_q    <= m5_d;
    pm5_q   <= pm4_q;
    rel5_q  <= rel4_q;
    inv5_q  <= inv4_q;
    kill5_q <= kill4_q;
    pos5_q  <= pos4_q;
    om5_q   <= om4_q;
  end

  // --------------------------------------------------------------------------
  // stage 6: non-premixed source times (1-c), model select, zeroing
  // --------------------------------------------------------------------------
  logic [RATE_W+FRAC_W-1:0]  np_prod;
  logic [RATE_W-1:0]         psrc6_d, psrc6_q;
  logic signed [MSRC_W-1:0]  msrc6_d, msrc6_q;
  logic signed [MSRC_W-1:0]  rel_s;
  logic                      inv6_q;

  always_comb begin
    np_prod = (RATE_W+FRAC_W)'(m5_q) * (RATE_W+FRAC_W)'(om5_q);
    rel_s   = $signed({1'b0, rel5_q});
    psrc6_d = '0;
    msrc6_d = '0;
    if (!kill5_q) begin
      if (cfg.model_mode == MODE_NON_PREMIXED) begin
        psrc6_d = np_prod[FB+RATE_W-1:FB];
        // relaxation pulls z back toward stoichiometric
        msrc6_d = pos5_q ? -rel_s : rel_s;
      end else begin
        psrc6_d = pm5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    psrc6_q <= psrc6_d;
    msrc6_q <= msrc6_d;
    inv6_q  <= inv5_q;
  end

  // --------------------------------------------------------------------------
  // stage 7: heat release with 48-bit saturation, output registers
  // --------------------------------------------------------------------------
  logic [63:0]               h_prod, h_full;
  logic [HEAT_W-1:0]         heat7_d, heat7_q;
  logic [RATE_W-1:0]         psrc7_q;
  logic signed [MSRC_W-1:0]  msrc7_q;
  logic                      inv7_q;

  always_comb begin
    h_prod  = 64'(cfg.heat_gain) * 64'(psrc6_q);
    h_full  = h_prod >> FB;
    heat7_d = (|h_full[63:HEAT_W]) ? '1 : h_full[HEAT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    heat7_q <= heat7_d;
    psrc7_q <= psrc6_q;
    msrc7_q <= msrc6_q;
    inv7_q  <= inv6_q;
  end

  assign result_valid_o  = vld_q[STAGES];
  assign prog_src_o      = psrc7_q;
  assign mix_src_o       = msrc7_q;
  assign heat_rate_o     = heat7_q;
  assign invalid_state_o = inv7_q;

endmodule
